### hw/rtl/tor_pkg.sv
// ----------------------------------------------------------------------------
// tor_pkg
// Shared types and constants for the timestamp ordered request queue.
// ----------------------------------------------------------------------------
package tor_pkg;

	// operation codes carried on func; code 3 is unused, changes nothing and returns a done result
	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_QUERY  = 2'd2
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;

	// width and reset value of the resource count register
	localparam int unsigned RES_W = 5;
	localparam logic [RES_W-1:0] RES_RESET = 5'd1;

	// one stored request
	typedef struct packed {
		logic [31:0] ts;
		logic [7:0]  src;
	} entry_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_RESP
	} state_t;

endpackage

### hw/rtl/timestamp_ordered_request_queue.sv
// ----------------------------------------------------------------------------
// timestamp_ordered_request_queue
// Request list sorted by timestamp then source id, with insert, remove by
// source and grant query against the leading resource_count entries.
//
//   channel   signals                              direction
//   request   in_valid/in_ready, func, timestamp,  in
//             source_id
//   result    out_valid/out_ready, status,         out
//             granted, entry_count
//   config    cfg_wr_en, cfg_wr_data               in
//
// One word at a time; every store step is a read then a compare or write.
// Insert moves entries back until the new one fits, remove scans for the
// source and pulls later entries forward, query scans only the grant window;
// the sequencer returns to idle before it takes the next word.
// Reset clears the entry count and resource_count returns to 1; the entry
// store itself is not cleared. A new word is taken while the last result
// still waits; a stalled result holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module timestamp_ordered_request_queue
	import tor_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         func,
	input  logic [31:0]                        timestamp,
	input  logic [7:0]                         source_id,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic                               granted,
	output logic [$clog2(QUEUE_DEPTH + 1)-1:0] entry_count,
	input  logic                               cfg_wr_en,
	input  logic [RES_W-1:0]                   cfg_wr_data
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic [RES_W-1:0] resource_count_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [AW-1:0]    mem_raddr;
	entry_t           mem_wdata;
	entry_t           mem_rdata;

	// resource count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resource_count_q <= RES_RESET;
		end else if (cfg_wr_en) begin
			resource_count_q <= cfg_wr_data;
		end
	end

	tor_mem #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tor_ctrl #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.timestamp      (timestamp),
		.source_id      (source_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.granted        (granted),
		.entry_count    (entry_count),
		.resource_count (resource_count_q),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

endmodule

### hw/rtl/tor_mem.sv
// ----------------------------------------------------------------------------
// tor_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tor_mem
	import tor_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/tor_ctrl.sv
// ----------------------------------------------------------------------------
// tor_ctrl
// Sequencer: walks the entry store to insert, remove or look up a request,
// and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module tor_ctrl
	import tor_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4,
	parameter int unsigned CW    = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       func,
	input  logic [31:0]      timestamp,
	input  logic [7:0]       source_id,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic             granted,
	output logic [CW-1:0]    entry_count,
	// resource count register
	input  logic [RES_W-1:0] resource_count,
	// entry store
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output entry_t           mem_wdata,
	output logic [AW-1:0]    mem_raddr,
	input  entry_t           mem_rdata
);

	// common width for window compare
	localparam int unsigned WW = (CW > RES_W) ? CW : RES_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          out_valid_q, out_valid_d;

	logic [CW-1:0] pos_q, pos_d;
	logic          is_remove_q, is_remove_d;
	entry_t        req_q, req_d;
	status_t       stat_q, stat_d;
	logic          grant_q, grant_d;

	logic [1:0]    status_q, status_od;
	logic          granted_q, granted_od;
	logic [CW-1:0] entry_count_q, entry_count_od;

	logic [WW-1:0] window;
	logic [CW-1:0] limit;
	logic          goes_after;

	// grant window is min(count, resource_count)
	always_comb begin
		if (WW'(count_q) < WW'(resource_count)) begin
			window = WW'(count_q);
		end else begin
			window = WW'(resource_count);
		end
	end

	// remove scans all entries, query only the window
	assign limit = is_remove_q ? count_q : CW'(window);

	// stored entry must stand after the new request
	always_comb begin
		if (mem_rdata.ts != req_q.ts) begin
			goes_after = mem_rdata.ts > req_q.ts;
		end else begin
			goes_after = mem_rdata.src > req_q.src;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// next state and store accesses
	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		out_valid_d    = out_valid_q;
		pos_d          = pos_q;
		is_remove_d    = is_remove_q;
		req_d          = req_q;
		stat_d         = stat_q;
		grant_d        = grant_q;
		status_od      = status_q;
		granted_od     = granted_q;
		entry_count_od = entry_count_q;
		mem_we         = 1'b0;
		mem_waddr      = pos_q[AW-1:0];
		mem_wdata      = req_q;
		mem_raddr      = pos_q[AW-1:0];

		// result word taken
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_d.ts    = timestamp;
					req_d.src   = source_id;
					stat_d      = STAT_DONE;
					grant_d     = 1'b0;
					is_remove_d = 1'b0;
					pos_d       = '0;
					case (func_t'(func))
						FUNC_INSERT: begin
							if (count_q == FULL_CNT) begin
								stat_d  = STAT_FULL;
								state_d = ST_RESP;
							end else begin
								pos_d   = count_q;
								state_d = ST_INS_RD;
							end
						end
						FUNC_REMOVE: begin
							is_remove_d = 1'b1;
							state_d     = ST_SCAN_RD;
						end
						FUNC_QUERY: begin
							state_d = ST_SCAN_RD;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			// insert: fetch the entry in front of the hole
			ST_INS_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					count_d = count_q + 1'b1;
					state_d = ST_RESP;
				end else begin
					mem_raddr = AW'(pos_q - 1'b1);
					state_d   = ST_INS_CMP;
				end
			end
			// insert: move the entry back or drop the new one in
			ST_INS_CMP: begin
				mem_we = 1'b1;
				if (goes_after) begin
					mem_wdata = mem_rdata;
					pos_d     = pos_q - 1'b1;
					state_d   = ST_INS_RD;
				end else begin
					count_d = count_q + 1'b1;
					state_d = ST_RESP;
				end
			end
			// search from the front for the source id
			ST_SCAN_RD: begin
				if (pos_q >= limit) begin
					if (is_remove_q) begin
						stat_d = STAT_NOT_FOUND;
					end
					state_d = ST_RESP;
				end else begin
					state_d = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				if (mem_rdata.src == req_q.src) begin
					if (is_remove_q) begin
						state_d = ST_SHIFT_RD;
					end else begin
						grant_d = 1'b1;
						state_d = ST_RESP;
					end
				end else begin
					pos_d   = pos_q + 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			// remove: pull later entries forward over the gap
			ST_SHIFT_RD: begin
				if ((pos_q + 1'b1) >= count_q) begin
					count_d = count_q - 1'b1;
					state_d = ST_RESP;
				end else begin
					mem_raddr = AW'(pos_q + 1'b1);
					state_d   = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				pos_d     = pos_q + 1'b1;
				state_d   = ST_SHIFT_RD;
			end
			// load the result word once the slot is free
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d    = 1'b1;
					status_od      = stat_q;
					granted_od     = grant_q;
					entry_count_od = count_q;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		pos_q         <= pos_d;
		is_remove_q   <= is_remove_d;
		req_q         <= req_d;
		stat_q        <= stat_d;
		grant_q       <= grant_d;
		status_q      <= status_od;
		granted_q     <= granted_od;
		entry_count_q <= entry_count_od;
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign granted     = granted_q;
	assign entry_count = entry_count_q;

endmodule
